>>> rtl/ccx_pkg.sv
// ----------------------------------------------------------------------------
// ccx_pkg: shared types and constants for the stream cipher XOR unit
// Holds the cipher constants, default round count and front-to-back word type.
// ----------------------------------------------------------------------------
package ccx_pkg;

  localparam int DoubleRoundsDefault = 10;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_KEY_LOW      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_MID_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_MID_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NONCE        = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_START_CTR    = 3'd5;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // classified word from the front end
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        restart;
  } word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } state_t;

  function automatic logic [127:0] quarter_round(input logic [127:0] q);
    logic [31:0] a, b, c, d;
    begin
      a = q[31:0]; b = q[63:32]; c = q[95:64]; d = q[127:96];
      a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
      c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
      a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
      c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
      return {d, c, b, a};
    end
  endfunction

endpackage

>>> rtl/chacha20_stream_xor_unit.sv
// Words from a ready keystream block pass the queue, the back end's idle and
// emit states and the output register; a word that needs a new block first
// waits for the double rounds and the feed-forward. The back end goes back to
// idle after each word it takes, so it cannot take a new word until it is done
// with the last. Reset: rst clears config registers, counter, position and
// queue; keystream is rebuilt before first use.
// ----------------------------------------------------------------------------
// chacha20_stream_xor_unit: stream cipher XOR unit
// Front end queues input words, back end builds keystream blocks and XORs.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_unit #(
  parameter int DOUBLE_ROUNDS = ccx_pkg::DoubleRoundsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_in,
  input  logic [2:0]  valid_bytes,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] data_out,
  output logic [2:0]  out_bytes
);

  logic [63:0]    key_low, key_mid_low, key_mid_high, key_high, nonce, start_counter;
  logic           q_valid, q_ready;
  ccx_pkg::word_t q_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0; key_mid_low <= '0; key_mid_high <= '0;
      key_high <= '0; nonce <= '0; start_counter <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ccx_pkg::REG_KEY_LOW:      key_low       <= cfg_data;
        ccx_pkg::REG_KEY_MID_LOW:  key_mid_low   <= cfg_data;
        ccx_pkg::REG_KEY_MID_HIGH: key_mid_high  <= cfg_data;
        ccx_pkg::REG_KEY_HIGH:     key_high      <= cfg_data;
        ccx_pkg::REG_NONCE:        nonce         <= cfg_data;
        ccx_pkg::REG_START_CTR:    start_counter <= cfg_data;
        default: ;
      endcase
    end
  end

  ccx_front u_front (
    .clk, .rst, .in_valid, .in_ready, .data_in, .valid_bytes, .restart,
    .q_valid, .q_ready, .q_word
  );

  ccx_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
    .clk, .rst, .key_low, .key_mid_low, .key_mid_high, .key_high, .nonce,
    .start_counter, .q_valid, .q_ready, .q_word, .out_valid, .out_ready,
    .data_out, .out_bytes
  );

endmodule

>>> rtl/ccx_front.sv
// ----------------------------------------------------------------------------
// ccx_front: input stage and word queue
// Accepts input words, clamps the byte count and queues them for the back end.
// ----------------------------------------------------------------------------
module ccx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       data_in,
  input  logic [2:0]        valid_bytes,
  input  logic              restart,
  output logic              q_valid,
  input  logic              q_ready,
  output ccx_pkg::word_t    q_word
);

  ccx_pkg::word_t slot [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     fill;
  ccx_pkg::word_t w_in;
  logic           push, pop;

  always_comb begin
    w_in.data    = data_in;
    w_in.count   = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    w_in.restart = restart;
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_word   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= w_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 |-> !push)
    else $error("push into full queue");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 || fill == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers out of step");
`endif

endmodule

>>> rtl/ccx_back.sv
// ----------------------------------------------------------------------------
// ccx_back: keystream generator and XOR stage
// Runs the double rounds on one quarter-round column or diagonal set per cycle
// and XORs each queued word with the next keystream word.
// ----------------------------------------------------------------------------
module ccx_back #(
  parameter int DOUBLE_ROUNDS = ccx_pkg::DoubleRoundsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [63:0]       key_low,
  input  logic [63:0]       key_mid_low,
  input  logic [63:0]       key_mid_high,
  input  logic [63:0]       key_high,
  input  logic [63:0]       nonce,
  input  logic [63:0]       start_counter,
  input  logic              q_valid,
  output logic              q_ready,
  input  ccx_pkg::word_t    q_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       data_out,
  output logic [2:0]        out_bytes
);

  localparam int HalfRounds = 2 * DOUBLE_ROUNDS;
  localparam int RndW = $clog2(HalfRounds + 1);

  ccx_pkg::state_t state, state_next;
  logic [31:0]     w [16];
  logic [31:0]     init [16];
  logic [63:0]     block_counter;
  logic [3:0]      word_position;
  logic            block_ready;
  logic [RndW-1:0] rnd;
  logic            restart_seen;
  logic            out_full;
  logic [31:0]     ks;
  logic [31:0]     mask;
  logic [63:0]     ctr_eff;
  logic [127:0]    qr_out [4];
  logic            take;

  assign ctr_eff = q_word.restart ? start_counter : block_counter;
  assign ks = w[word_position];
  assign out_valid = out_full;

  always_comb begin
    case (q_word.count)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  // column pass on even half rounds, diagonal pass on odd
  always_comb begin
    if (!rnd[0]) begin
      for (int i = 0; i < 4; i++) begin
        qr_out[i] = ccx_pkg::quarter_round({w[12+i], w[8+i], w[4+i], w[i]});
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        qr_out[i] = ccx_pkg::quarter_round({w[12+((i+3)%4)], w[8+((i+2)%4)],
                                            w[4+((i+1)%4)], w[i]});
      end
    end
  end

  assign take = (state == ccx_pkg::ST_EMIT) && q_valid && (!out_full || out_ready);

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    case (state)
      ccx_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_word.restart || !block_ready) state_next = ccx_pkg::ST_ROUND;
          else state_next = ccx_pkg::ST_EMIT;
        end
      end
      ccx_pkg::ST_ROUND: begin
        if (rnd == RndW'(HalfRounds - 1)) state_next = ccx_pkg::ST_FEED;
      end
      ccx_pkg::ST_FEED: state_next = ccx_pkg::ST_EMIT;
      ccx_pkg::ST_EMIT: begin
        q_ready = !out_full || out_ready;
        if (take) state_next = ccx_pkg::ST_IDLE;
      end
      default: state_next = ccx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccx_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      word_position <= '0;
      block_ready   <= 1'b0;
      rnd           <= '0;
      out_full      <= 1'b0;
      restart_seen  <= 1'b0;
    end else begin
      if (take) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
      case (state)
        ccx_pkg::ST_IDLE: begin
          if (q_valid && (q_word.restart || !block_ready)) begin
            restart_seen <= q_word.restart;
            rnd <= '0;
          end
        end
        ccx_pkg::ST_ROUND: rnd <= rnd + 1'b1;
        ccx_pkg::ST_FEED: begin
          block_counter <= ctr_eff + 64'd1;
          word_position <= '0;
          block_ready   <= 1'b1;
        end
        ccx_pkg::ST_EMIT: begin
          if (take) begin
            word_position <= word_position + 4'd1;
            if (word_position == 4'd15) block_ready <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // load, rounds and feed-forward on the working state
  always_ff @(posedge clk) begin
    case (state)
      ccx_pkg::ST_IDLE: begin
        if (q_valid && (q_word.restart || !block_ready)) begin
          init[0]  <= ccx_pkg::SIGMA0;       init[1]  <= ccx_pkg::SIGMA1;
          init[2]  <= ccx_pkg::SIGMA2;       init[3]  <= ccx_pkg::SIGMA3;
          init[4]  <= key_low[31:0];         init[5]  <= key_low[63:32];
          init[6]  <= key_mid_low[31:0];     init[7]  <= key_mid_low[63:32];
          init[8]  <= key_mid_high[31:0];    init[9]  <= key_mid_high[63:32];
          init[10] <= key_high[31:0];        init[11] <= key_high[63:32];
          init[12] <= ctr_eff[31:0];         init[13] <= ctr_eff[63:32];
          init[14] <= nonce[31:0];           init[15] <= nonce[63:32];
          w[0]  <= ccx_pkg::SIGMA0;          w[1]  <= ccx_pkg::SIGMA1;
          w[2]  <= ccx_pkg::SIGMA2;          w[3]  <= ccx_pkg::SIGMA3;
          w[4]  <= key_low[31:0];            w[5]  <= key_low[63:32];
          w[6]  <= key_mid_low[31:0];        w[7]  <= key_mid_low[63:32];
          w[8]  <= key_mid_high[31:0];       w[9]  <= key_mid_high[63:32];
          w[10] <= key_high[31:0];           w[11] <= key_high[63:32];
          w[12] <= ctr_eff[31:0];            w[13] <= ctr_eff[63:32];
          w[14] <= nonce[31:0];              w[15] <= nonce[63:32];
        end
      end
      ccx_pkg::ST_ROUND: begin
        if (!rnd[0]) begin
          for (int i = 0; i < 4; i++) begin
            w[i]    <= qr_out[i][31:0];
            w[4+i]  <= qr_out[i][63:32];
            w[8+i]  <= qr_out[i][95:64];
            w[12+i] <= qr_out[i][127:96];
          end
        end else begin
          for (int i = 0; i < 4; i++) begin
            w[i]             <= qr_out[i][31:0];
            w[4+((i+1)%4)]   <= qr_out[i][63:32];
            w[8+((i+2)%4)]   <= qr_out[i][95:64];
            w[12+((i+3)%4)]  <= qr_out[i][127:96];
          end
        end
      end
      ccx_pkg::ST_FEED: begin
        for (int i = 0; i < 16; i++) w[i] <= w[i] + init[i];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_out  <= (q_word.data ^ ks) & mask;
      out_bytes <= q_word.count;
    end
  end

`ifndef SYNTHESIS
  a_take_restart: assert property (@(posedge clk) disable iff (rst)
    take |-> block_ready)
    else $error("word taken without keystream");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_full && !out_ready |=> out_full && $stable(data_out))
    else $error("result dropped while stalled");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    state == ccx_pkg::ST_ROUND |-> rnd < RndW'(HalfRounds))
    else $error("round count overrun");
  a_restart_used: assert property (@(posedge clk) disable iff (rst)
    state == ccx_pkg::ST_FEED && restart_seen |-> q_word.restart)
    else $error("restart word lost during block build");
`endif

endmodule
